// ----- sv/hop_pkg.sv -----
// ----------------------------------------------------------------------------
// hop_pkg: shared constants and types for the Hopfield train/recall block
// Network size, fixed-point widths, stream widths, mode codes and FSM states.
// ----------------------------------------------------------------------------
package hop_pkg;

    // Network size and field widths
    localparam int NEURONS     = 20;
    localparam int PAT_W       = 20;
    localparam int IDX_W       = 5;
    localparam int WGT_W       = 32;
    localparam int FRAC_W      = 16;

    // Row index and adder tree shape
    localparam int ROW_W       = $clog2(NEURONS);
    localparam int TREE_LEAVES = 1 << ROW_W;
    localparam int ROW_BITS    = NEURONS * WGT_W;

    // Exact field sum, scaled field and update step widths
    localparam int FIELD_W     = WGT_W + 1 + ROW_W;
    localparam int COEF_W      = 17;
    localparam int PROD_W      = FIELD_W + COEF_W;
    localparam int STEP_W      = PROD_W + 2;

    // Stream widths
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 56;

    // 1/N as rounded Q0.16, kept positive in a signed word
    localparam logic signed [COEF_W-1:0] INV_N =
        COEF_W'(((1 << FRAC_W) + NEURONS / 2) / NEURONS);

    // Saturation limits of a Q16.16 weight
    localparam logic signed [WGT_W-1:0] WGT_MAX = {1'b0, {(WGT_W-1){1'b1}}};
    localparam logic signed [WGT_W-1:0] WGT_MIN = {1'b1, {(WGT_W-1){1'b0}}};

    // Item modes
    localparam logic MODE_TRAIN  = 1'b0;
    localparam logic MODE_RECALL = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIELD,
        ST_DRAIN,
        ST_UPDATE,
        ST_RECALL,
        ST_WAIT,
        ST_FINISH
    } hop_state_t;

endpackage

// ----- sv/hopfield_storkey_train_recall.sv -----
// ----------------------------------------------------------------------------
// hopfield_storkey_train_recall: Hopfield weight store with Storkey training
// Train: a field pass reads every row through the adder tree, then an update pass
//   reads and writes back every row; two row reads per row.
// Recall: one row read and the registered adder tree; a bad index skips both.
//   A new item is taken only once the last result is in the output register.
// Reset clears the threshold and all row valid bits, so every weight reads 0.
// ----------------------------------------------------------------------------
module hopfield_storkey_train_recall
    import hop_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [WGT_W-1:0]    cfg_wr_data,    // firing_threshold, signed Q16.16
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // [19:0] pattern, [24:20] neuron_index
    input  logic [0:0]          s_axis_tuser,   // [0] mode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata    // [19:0] pattern_out, [51:20] local_field
);

    localparam int SH_W  = STEP_W - FRAC_W;
    localparam int SUM_W = SH_W + 1;
    localparam int EXT_W = NEURONS + PAT_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NEURONS - 1);
    localparam logic signed [STEP_W-1:0] STEP_ONE  = STEP_W'(INV_N) <<< FRAC_W;
    localparam logic signed [STEP_W-1:0] STEP_HALF = STEP_W'(1) <<< (FRAC_W - 1);

    // Sequencer and item
    hop_state_t                state_reg;
    hop_state_t                state_next;
    logic                      mode_reg;
    logic [PAT_W-1:0]          pat_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;
    logic signed [WGT_W-1:0]   thr_reg;
    logic                      in_xfer;
    logic                      in_range;
    logic                      fld_issue;
    logic                      upd_issue;
    logic                      rd_en;
    logic [ROW_W-1:0]          rd_addr;
    logic                      rcl_done;
    logic                      out_load;

    // Weight memory, one row per neuron
    logic [ROW_BITS-1:0]       mem [NEURONS];
    logic [NEURONS-1:0]        row_valid_reg;
    logic [ROW_BITS-1:0]       rd_data_reg;
    logic                      rd_rv_reg;

    // Field tree
    logic [ROW_W:0]            tv_reg;
    logic [ROW_W-1:0]          tr_reg [0:ROW_W];
    logic [EXT_W-1:0]          pat_ext;
    logic [NEURONS-1:0]        v_vec;
    logic signed [FIELD_W-1:0] tree_val [1:2*TREE_LEAVES-1];
    logic signed [FIELD_W-1:0] node_reg [1:TREE_LEAVES-1];
    logic signed [PROD_W-1:0]  fh_prod;
    logic signed [PROD_W-1:0]  fh_reg [NEURONS];

    // Update path
    logic signed [SH_W-1:0]    step_comb [NEURONS];
    logic signed [SH_W-1:0]    step_reg [NEURONS];
    logic                      upd_valid_reg;
    logic [ROW_W-1:0]          upd_row_reg;
    logic [ROW_BITS-1:0]       new_row;

    // Results
    logic                      fire;
    logic signed [WGT_W-1:0]   field_sat;
    logic [PAT_W-1:0]          rcl_pat;
    logic [PAT_W-1:0]          res_pat_reg;
    logic signed [WGT_W-1:0]   res_field_reg;
    logic                      out_valid_reg;
    logic [PAT_W-1:0]          out_pat_reg;
    logic signed [WGT_W-1:0]   out_field_reg;

    // Decode the input transfer
    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign in_range = int'(s_axis_tdata[PAT_W +: IDX_W]) < NEURONS;
    assign rd_en    = fld_issue | upd_issue;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser[0] == MODE_TRAIN)
                        state_next = ST_FIELD;
                    else if (in_range)
                        state_next = ST_RECALL;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_FIELD:
            begin
                if (row_reg == LAST_ROW)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (tv_reg == '0)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (row_reg == LAST_ROW)
                    state_next = ST_FINISH;
            end
            ST_RECALL:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (tv_reg[ROW_W])
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        fld_issue     = 1'b0;
        upd_issue     = 1'b0;
        rd_addr       = row_reg;
        row_next      = row_reg;
        rcl_done      = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                row_next      = '0;
            end
            ST_FIELD:
            begin
                fld_issue = 1'b1;
                row_next  = (row_reg == LAST_ROW) ? '0 : row_reg + ROW_W'(1);
            end
            ST_DRAIN:
            begin
                row_next = '0;
            end
            ST_UPDATE:
            begin
                upd_issue = 1'b1;
                row_next  = (row_reg == LAST_ROW) ? '0 : row_reg + ROW_W'(1);
            end
            ST_RECALL:
            begin
                fld_issue = 1'b1;
                rd_addr   = ROW_W'(idx_reg);
            end
            ST_WAIT:
            begin
                rcl_done = tv_reg[ROW_W];
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                row_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            thr_reg       <= '0;
            tv_reg        <= '0;
            upd_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            tv_reg        <= {tv_reg[ROW_W-1:0], fld_issue};
            upd_valid_reg <= upd_issue;
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            if (upd_valid_reg)
                row_valid_reg[upd_row_reg] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Weight memory: row write-back and registered row read
    always_ff @(posedge clk)
    begin
        if (upd_valid_reg)
            mem[upd_row_reg] <= new_row;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_rv_reg   <= row_valid_reg[rd_addr];
        end
    end

    // Expand the pattern; neurons without an input bit read as -1
    always_comb
    begin
        pat_ext = EXT_W'(pat_reg);
        v_vec   = pat_ext[NEURONS-1:0];
    end

    // Signed tree leaves from the row just read; mask the self weight on recall
    always_comb
    begin
        logic signed [FIELD_W-1:0] w_lane;
        for (int k = 1; k < TREE_LEAVES; k++)
            tree_val[k] = node_reg[k];
        for (int k = 0; k < TREE_LEAVES; k++)
            tree_val[TREE_LEAVES + k] = '0;
        for (int k = 0; k < NEURONS; k++)
        begin
            w_lane = rd_rv_reg ? FIELD_W'($signed(rd_data_reg[k*WGT_W +: WGT_W])) : '0;
            if (mode_reg == MODE_RECALL && tr_reg[0] == ROW_W'(k))
                tree_val[TREE_LEAVES + k] = '0;
            else
                tree_val[TREE_LEAVES + k] = v_vec[k] ? w_lane : -w_lane;
        end
    end

    // Advance the adder tree one level per cycle
    always_ff @(posedge clk)
    begin
        for (int k = 1; k < TREE_LEAVES; k++)
            node_reg[k] <= tree_val[2*k] + tree_val[2*k+1];
    end

    // Scale each finished field by 1/N
    assign fh_prod = node_reg[1] * INV_N;

    // Storkey step for every lane of the current row
    always_comb
    begin
        logic                      v_i;
        logic signed [STEP_W-1:0]  fh_i;
        logic signed [STEP_W-1:0]  acc;
        fh_i = STEP_W'(fh_reg[row_reg]);
        v_i  = v_vec[row_reg];
        for (int j = 0; j < NEURONS; j++)
        begin
            acc = (v_i == v_vec[j]) ? STEP_ONE : -STEP_ONE;
            acc = acc + (v_i ? -STEP_W'(fh_reg[j]) : STEP_W'(fh_reg[j]));
            acc = acc + (v_vec[j] ? -fh_i : fh_i);
            acc = acc + STEP_HALF;
            step_comb[j] = acc[STEP_W-1:FRAC_W];
        end
    end

    // Add the step to the old weight, saturate, zero the diagonal
    always_comb
    begin
        logic signed [WGT_W-1:0] w_old;
        logic signed [SUM_W-1:0] w_sum;
        for (int j = 0; j < NEURONS; j++)
        begin
            w_old = rd_rv_reg ? $signed(rd_data_reg[j*WGT_W +: WGT_W]) : '0;
            w_sum = SUM_W'(w_old) + SUM_W'(step_reg[j]);
            if (upd_row_reg == ROW_W'(j))
                new_row[j*WGT_W +: WGT_W] = '0;
            else if (w_sum > SUM_W'(WGT_MAX))
                new_row[j*WGT_W +: WGT_W] = WGT_MAX;
            else if (w_sum < SUM_W'(WGT_MIN))
                new_row[j*WGT_W +: WGT_W] = WGT_MIN;
            else
                new_row[j*WGT_W +: WGT_W] = w_sum[WGT_W-1:0];
        end
    end

    // Threshold test and saturation of the recall field
    always_comb
    begin
        logic signed [FIELD_W-1:0] root;
        root = node_reg[1];
        fire = root >= FIELD_W'(thr_reg);
        if (root > FIELD_W'(WGT_MAX))
            field_sat = WGT_MAX;
        else if (root < FIELD_W'(WGT_MIN))
            field_sat = WGT_MIN;
        else
            field_sat = root[WGT_W-1:0];
        for (int b = 0; b < PAT_W; b++)
            rcl_pat[b] = (int'(idx_reg) == b) ? fire : pat_reg[b];
    end

    // Item, tag pipeline, scaled fields, steps and result registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg      <= s_axis_tuser[0];
            pat_reg       <= s_axis_tdata[PAT_W-1:0];
            idx_reg       <= s_axis_tdata[PAT_W +: IDX_W];
            res_pat_reg   <= s_axis_tdata[PAT_W-1:0];
            res_field_reg <= '0;
        end
        if (rcl_done)
        begin
            res_pat_reg   <= rcl_pat;
            res_field_reg <= field_sat;
        end
        tr_reg[0] <= rd_addr;
        for (int l = 1; l <= ROW_W; l++)
            tr_reg[l] <= tr_reg[l-1];
        if (tv_reg[ROW_W] && mode_reg == MODE_TRAIN)
            fh_reg[tr_reg[ROW_W]] <= fh_prod;
        if (upd_issue)
        begin
            step_reg    <= step_comb;
            upd_row_reg <= row_reg;
        end
        if (out_load)
        begin
            out_pat_reg   <= res_pat_reg;
            out_field_reg <= res_field_reg;
        end
    end

    // Drive the result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_W'({out_field_reg, out_pat_reg});

endmodule

// ----- sv/hop_chk.sv -----
// ----------------------------------------------------------------------------
// hop_chk: port-level checks for the Hopfield train/recall block
// Watches the stream ports for item ordering and result hold behavior.
// ----------------------------------------------------------------------------
module hop_chk
    import hop_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    // One item at a time: ready drops right after an input transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is still at work");

    // A new result only appears after the block has been busy
    a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result raised without a preceding busy cycle");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before transfer");

    // Keep stalled result data steady
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

endmodule

bind hopfield_storkey_train_recall hop_chk u_hop_chk (.*);

// ----- tb/tb_hopfield_storkey_train_recall.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hopfield_storkey_train_recall: regression for the Hopfield train/recall block
// Streams train and recall items through the block and predicts every result
// with a local copy of the weight matrix and threshold. Results are checked
// in order against that prediction. The run covers idle-free traffic, sender
// gaps, receiver stalls, a long receiver hold-off and several threshold values.
// ----------------------------------------------------------------------------
module tb_hopfield_storkey_train_recall;
    import hop_pkg::*;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 10;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     WATCHDOG_MAX  = 4000;
    localparam int     SQUEEZE_LEN   = 800;
    localparam int     PHASE_ITEMS   = 240;
    localparam int     BANK_DEPTH    = 6;
    localparam longint ONE_Q16       = 64'sd65536;
    localparam longint HALF_LSB      = 64'sd32768;
    // rounded 1/N in Q0.16
    localparam longint RECIP_N       = ((64'sd65536) + NEURONS / 2) / NEURONS;

    typedef struct packed {
        logic             mode;
        logic [PAT_W-1:0] pattern;
        logic [IDX_W-1:0] idx;
    } hop_item_t;

    typedef struct packed {
        logic [PAT_W-1:0]        pattern;
        logic signed [WGT_W-1:0] field;
    } hop_result_t;

    // DUT inputs, known from time zero
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [WGT_W-1:0]    cfg_wr_data   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [0:0]          s_axis_tuser  = '0;
    logic                m_axis_tready = 1'b0;
    logic                s_axis_tready;
    logic                m_axis_tvalid;
    logic [M_DATA_W-1:0] m_axis_tdata;

    // Model state
    logic signed [WGT_W-1:0] weight_q16 [NEURONS*NEURONS];
    longint                  thr_q16 = 0;

    // Stimulus and expectation stores
    hop_item_t        item_q[$];
    hop_result_t      result_q[$];
    logic [PAT_W-1:0] learned_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit squeeze_on     = 1'b0;
    int squeeze_cnt    = 0;

    int queued_total   = 0;
    int accepted_total = 0;
    int err_cnt        = 0;
    int stall_cycles   = 0;
    int n_train        = 0;
    int n_recall       = 0;
    int n_bad_idx      = 0;
    int n_fired        = 0;
    int n_cfg          = 0;
    int n_checked      = 0;

    hop_item_t   drv_item;
    hop_result_t got_res;
    hop_result_t exp_res;

    hopfield_storkey_train_recall u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Toggle the clock
    always #(CLK_HALF) clk = ~clk;

    function automatic bit neuron_on(input logic [PAT_W-1:0] pat, input int j);
        if (j < PAT_W)
            return pat[j];
        return 1'b0;
    endfunction

    function automatic logic signed [WGT_W-1:0] clamp_q16(input longint x);
        if (x > longint'(WGT_MAX))
            return WGT_MAX;
        if (x < longint'(WGT_MIN))
            return WGT_MIN;
        return x[WGT_W-1:0];
    endfunction

    // Apply one Storkey update for a bipolar pattern
    function automatic void storkey_train(input logic [PAT_W-1:0] pat);
        longint hsum [NEURONS];
        longint acc;
        longint w;
        longint step;
        bit     vi;
        bit     vj;
        for (int i = 0; i < NEURONS; i++)
        begin
            acc = 0;
            for (int j = 0; j < NEURONS; j++)
            begin
                w = longint'(weight_q16[i*NEURONS + j]);
                acc += neuron_on(pat, j) ? w : -w;
            end
            hsum[i] = acc;
        end
        for (int i = 0; i < NEURONS; i++)
        begin
            vi = neuron_on(pat, i);
            for (int j = 0; j < NEURONS; j++)
            begin
                if (i == j)
                begin
                    weight_q16[i*NEURONS + j] = '0;
                end
                else
                begin
                    vj   = neuron_on(pat, j);
                    step = (vi == vj) ? ONE_Q16 : -ONE_Q16;
                    step += vi ? -hsum[j] : hsum[j];
                    step += vj ? -hsum[i] : hsum[i];
                    // round half up back to Q16.16
                    step = (step * RECIP_N + HALF_LSB) >>> 16;
                    weight_q16[i*NEURONS + j] =
                        clamp_q16(longint'(weight_q16[i*NEURONS + j]) + step);
                end
            end
        end
    endfunction

    // Predict the result of one accepted item and update the model
    function automatic hop_result_t predict_item(input hop_item_t it);
        hop_result_t r;
        longint      acc;
        longint      w;
        int          i;
        r.pattern = it.pattern;
        r.field   = '0;
        if (it.mode == MODE_TRAIN)
        begin
            storkey_train(it.pattern);
            n_train++;
        end
        else if (int'(it.idx) >= NEURONS)
        begin
            n_bad_idx++;
        end
        else
        begin
            i   = int'(it.idx);
            acc = 0;
            for (int j = 0; j < NEURONS; j++)
            begin
                if (j != i)
                begin
                    w = longint'(weight_q16[i*NEURONS + j]);
                    acc += neuron_on(it.pattern, j) ? w : -w;
                end
            end
            // compare the exact field, report the saturated one
            if (i < PAT_W)
                r.pattern[i] = (acc >= thr_q16);
            if (acc >= thr_q16)
                n_fired++;
            r.field = clamp_q16(acc);
            n_recall++;
        end
        return r;
    endfunction

    // Driver: hold the item until transfer, then offer the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                drv_item.mode    = s_axis_tuser[0];
                drv_item.pattern = s_axis_tdata[PAT_W-1:0];
                drv_item.idx     = s_axis_tdata[PAT_W +: IDX_W];
                result_q.push_back(predict_item(drv_item));
                accepted_total++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_item      = item_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= S_DATA_W'({drv_item.idx, drv_item.pattern});
                    s_axis_tuser  <= drv_item.mode;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: long hold-off once under pressure, else random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (squeeze_on && squeeze_cnt < SQUEEZE_LEN)
        begin
            m_axis_tready <= 1'b0;
            squeeze_cnt   <= squeeze_cnt + 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res.pattern = m_axis_tdata[PAT_W-1:0];
            got_res.field   = m_axis_tdata[PAT_W +: WGT_W];
            if (result_q.size() == 0)
            begin
                if (err_cnt < 10)
                    $display("unexpected result pattern=%05h field=%08h",
                             got_res.pattern, got_res.field);
                err_cnt++;
            end
            else
            begin
                exp_res = result_q.pop_front();
                n_checked++;
                if (got_res.pattern !== exp_res.pattern || got_res.field !== exp_res.field)
                begin
                    if (err_cnt < 10)
                        $display("mismatch #%0d: pattern exp %05h got %05h, field exp %08h got %08h",
                                 n_checked, exp_res.pattern, got_res.pattern,
                                 exp_res.field, got_res.field);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: drop the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (accepted_total == queued_total && result_q.size() == 0))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_MAX)
            begin
                $display("watchdog: no transfer in %0d cycles", WATCHDOG_MAX);
                $display("hopfield_storkey_train_recall regression: fail");
                $finish;
            end
        end
    end

    task automatic push_item(input logic mode, input logic [PAT_W-1:0] pat,
                             input logic [IDX_W-1:0] idx);
        hop_item_t it;
        it.mode    = mode;
        it.pattern = pat;
        it.idx     = idx;
        item_q.push_back(it);
        queued_total++;
    endtask

    // Wait until every queued item is through and every result is in
    task automatic settle();
        while (accepted_total != queued_total || result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [WGT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        thr_q16 = longint'($signed(value));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        n_cfg++;
    endtask

    // Train on noise or stored patterns; recall mostly stored patterns with up to three flipped bits, else noise
    task automatic push_random_item();
        logic [PAT_W-1:0] pat;
        logic [IDX_W-1:0] idx;
        int               nflip;
        int               b;
        pat = PAT_W'($urandom());
        if ($urandom_range(99) < 35)
        begin
            if (learned_q.size() != 0 && $urandom_range(99) < 30)
                pat = learned_q[$urandom_range(learned_q.size() - 1)];
            learned_q.push_back(pat);
            if (learned_q.size() > BANK_DEPTH)
                void'(learned_q.pop_front());
            push_item(MODE_TRAIN, pat, IDX_W'($urandom()));
        end
        else
        begin
            if (learned_q.size() != 0 && $urandom_range(99) < 60)
            begin
                pat   = learned_q[$urandom_range(learned_q.size() - 1)];
                nflip = $urandom_range(3);
                for (int k = 0; k < nflip; k++)
                begin
                    b      = $urandom_range(PAT_W - 1);
                    pat[b] = ~pat[b];
                end
            end
            if ($urandom_range(99) < 10)
                idx = IDX_W'($urandom_range(31, NEURONS));
            else
                idx = IDX_W'($urandom_range(NEURONS - 1));
            push_item(MODE_RECALL, pat, idx);
        end
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct,
                                input logic [WGT_W-1:0] thr);
        write_threshold(thr);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
            push_random_item();
        settle();
    endtask

    initial
    begin
        // Clear the model weights, as reset clears the block
        foreach (weight_q16[k])
            weight_q16[k] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty matrix, range edges, out-of-range index
        write_threshold('0);
        push_item(MODE_RECALL, '0, 5'd0);
        push_item(MODE_RECALL, '1, 5'd19);
        push_item(MODE_RECALL, 20'hABCDE, 5'd20);
        push_item(MODE_RECALL, 20'h12345, 5'd31);
        push_item(MODE_TRAIN, '0, 5'd31);
        push_item(MODE_TRAIN, '1, 5'd0);
        push_item(MODE_TRAIN, 20'hAAAAA, 5'd0);
        push_item(MODE_TRAIN, 20'h55555, 5'd0);
        push_item(MODE_RECALL, 20'hAAAAA, 5'd0);
        push_item(MODE_RECALL, 20'h55554, 5'd19);
        push_item(MODE_RECALL, '1, 5'd7);
        push_item(MODE_RECALL, 20'hABCDE, 5'd25);
        settle();

        // Highest threshold: almost nothing fires
        write_threshold(WGT_MAX);
        push_item(MODE_RECALL, 20'hAAAAA, 5'd3);
        push_item(MODE_RECALL, '1, 5'd10);
        push_item(MODE_RECALL, 20'h55555, 5'd19);
        settle();

        // Lowest threshold: everything fires
        write_threshold(WGT_MIN);
        push_item(MODE_RECALL, 20'hAAAAA, 5'd3);
        push_item(MODE_RECALL, '0, 5'd0);
        push_item(MODE_RECALL, 20'h0F0F0, 5'd19);
        settle();

        // Threshold of one
        write_threshold(32'h0001_0000);
        push_item(MODE_RECALL, 20'h55555, 5'd1);
        push_item(MODE_RECALL, 20'hAAAAA, 5'd2);
        push_item(MODE_TRAIN, 20'hFF00F, 5'd0);
        push_item(MODE_RECALL, 20'hFF00F, 5'd4);
        settle();

        // Random phases under different flow control
        random_phase(0, 0, '0);
        random_phase(54, 0, WGT_W'($urandom_range(524288) - 262144));
        random_phase(0, 54, WGT_W'($urandom()));
        random_phase(25, 25, WGT_W'(-$urandom_range(131072)));

        // Pressure: long receiver hold-off while the sender keeps offering
        squeeze_on = 1'b1;
        random_phase(0, 10, WGT_W'($urandom_range(262144) - 131072));
        squeeze_on = 1'b0;

        settle();
        $display("covered %0d trains, %0d recalls (%0d fired), %0d out-of-range recalls",
                 n_train, n_recall, n_fired, n_bad_idx);
        $display("%0d results checked over %0d threshold settings, %0d errors",
                 n_checked, n_cfg, err_cnt);
        if (err_cnt == 0 && result_q.size() == 0)
            $display("hopfield_storkey_train_recall regression: pass");
        else
            $display("hopfield_storkey_train_recall regression: fail");
        $finish;
    end

endmodule

// ----- hopfield_storkey_train_recall.f -----
sv/hop_pkg.sv
sv/hopfield_storkey_train_recall.sv
sv/hop_chk.sv
tb/tb_hopfield_storkey_train_recall.sv
